/* src/multilevel_priority_fifo_macros.svh */
// ---------------------------------------------------------------------------
// multilevel priority fifo assertion macros
// shared concurrent assertion forms for the checker
// ---------------------------------------------------------------------------
`ifndef MULTILEVEL_PRIORITY_FIFO_MACROS_SVH
`define MULTILEVEL_PRIORITY_FIFO_MACROS_SVH

// same-cycle implication, disabled while in reset
`define MLPF_ASSERT_NOW(label, clock, resetn, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!resetn) (ante) |-> (cons)) \
        else $error("multilevel priority fifo check failed");

// next-cycle implication, disabled while in reset
`define MLPF_ASSERT_NEXT(label, clock, resetn, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!resetn) (ante) |=> (cons)) \
        else $error("multilevel priority fifo check failed");

`endif

/* src/mlpf_pkg.sv */
// ---------------------------------------------------------------------------
// mlpf_pkg
// field widths, stream packing and status codes of the priority fifo
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package mlpf_pkg;

    localparam int TASK_W    = 8;
    localparam int LEVEL_W   = 4;
    localparam int STATUS_W  = 2;

    localparam int S_TDATA_W = 16;
    localparam int S_TUSER_W = 1;
    localparam int M_TDATA_W = 16;
    localparam int M_TUSER_W = 3;

    typedef logic [STATUS_W-1:0] status_t;

    localparam logic ACT_ENQ = 1'b0;
    localparam logic ACT_DEQ = 1'b1;

    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_EMPTY = 2'd1;
    localparam status_t ST_DROP  = 2'd2;

endpackage

/* src/multilevel_priority_fifo.sv */
// a word's result is registered in the memory stage and then in the output register
// throughput: one word per cycle while s_axis_tready is high; each word makes at most one access to the entry memory
// the entry memory read is synchronous, so results pass through one memory stage
// reset: head, tail and occupancy of every level clear at once, no clearing pass
// entry memory contents are not reset; only written entries are ever read
// ---------------------------------------------------------------------------
// multilevel_priority_fifo
// per-level task fifos in one shared memory, dequeue from most urgent level
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module multilevel_priority_fifo #(
    parameter int LEVELS          = 16,
    parameter int DEPTH_PER_LEVEL = 16,
    parameter int ID_WIDTH        = 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [7:0] task_id, [11:8] level, [15:12] zero
    input  logic [mlpf_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // [0] action
    input  logic [mlpf_pkg::S_TUSER_W-1:0]  s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [7:0] out_task_id, [11:8] out_level, [15:12] zero
    output logic [mlpf_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    // [1:0] status, [2] all_empty
    output logic [mlpf_pkg::M_TUSER_W-1:0]  m_axis_tuser
);

    localparam int LVL_W     = $clog2(LEVELS);
    localparam int PTR_W     = $clog2(DEPTH_PER_LEVEL);
    localparam int CNT_W     = $clog2(DEPTH_PER_LEVEL + 1);
    localparam int ADDR_W    = LVL_W + PTR_W;
    localparam int MEM_DEPTH = LEVELS << PTR_W;

    typedef struct packed {
        logic                          deq_ok;
        logic [mlpf_pkg::LEVEL_W-1:0]  lvl;
        mlpf_pkg::status_t             status;
        logic                          all_empty;
    } result_ctl_t;

    // per-level control state
    logic [PTR_W-1:0] head_reg  [LEVELS];
    logic [PTR_W-1:0] head_next [LEVELS];
    logic [PTR_W-1:0] tail_reg  [LEVELS];
    logic [PTR_W-1:0] tail_next [LEVELS];
    logic [CNT_W-1:0] count_reg [LEVELS];
    logic [CNT_W-1:0] count_next[LEVELS];

    // entry memory
    logic [ID_WIDTH-1:0] entry_mem [MEM_DEPTH];
    logic [ID_WIDTH-1:0] rd_data_reg;

    // memory stage and output register
    logic        s1_valid_reg;
    logic        s1_valid_next;
    result_ctl_t s1_ctl_reg;
    result_ctl_t s1_ctl_next;
    logic                           out_valid_reg;
    logic                           out_valid_next;
    logic [mlpf_pkg::M_TDATA_W-1:0] out_data_reg;
    logic [mlpf_pkg::M_TDATA_W-1:0] out_data_next;
    logic [mlpf_pkg::M_TUSER_W-1:0] out_user_reg;
    logic [mlpf_pkg::M_TUSER_W-1:0] out_user_next;

    logic                          in_fire;
    logic                          in_act;
    logic [mlpf_pkg::TASK_W-1:0]   in_id;
    logic [mlpf_pkg::LEVEL_W-1:0]  in_level;
    logic [LVL_W-1:0]              enq_idx;
    logic                          enq_in_range;
    logic                          enq_full;
    logic                          enq_ok;
    logic [LVL_W-1:0]              deq_idx;
    logic                          deq_found;
    logic                          deq_ok;
    logic                          any_busy;
    logic                          out_free;
    logic [ADDR_W-1:0]             wr_addr;
    logic [ADDR_W-1:0]             rd_addr;
    logic [mlpf_pkg::TASK_W-1:0]   res_id;

    assign in_act   = s_axis_tuser[0];
    assign in_id    = s_axis_tdata[mlpf_pkg::TASK_W-1:0];
    assign in_level = s_axis_tdata[mlpf_pkg::TASK_W +: mlpf_pkg::LEVEL_W];

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !s1_valid_reg || out_free;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    assign enq_idx      = LVL_W'(in_level);
    assign enq_in_range = int'(in_level) < LEVELS;
    assign enq_full     = enq_in_range && (count_reg[enq_idx] == CNT_W'(DEPTH_PER_LEVEL));
    assign enq_ok       = (in_act == mlpf_pkg::ACT_ENQ) && enq_in_range && !enq_full;

    // priority encoder over non-empty levels, level 0 wins
    always_comb
    begin
        deq_idx   = '0;
        deq_found = 1'b0;
        for (int i = LEVELS - 1; i >= 0; i--)
        begin
            if (count_reg[i] != '0)
            begin
                deq_idx   = LVL_W'(i);
                deq_found = 1'b1;
            end
        end
    end

    assign deq_ok = (in_act == mlpf_pkg::ACT_DEQ) && deq_found;

    assign wr_addr = {enq_idx, tail_reg[enq_idx]};
    assign rd_addr = {deq_idx, head_reg[deq_idx]};

    // pointer and occupancy update, at most one level changes per word
    always_comb
    begin
        for (int i = 0; i < LEVELS; i++)
        begin
            head_next[i]  = head_reg[i];
            tail_next[i]  = tail_reg[i];
            count_next[i] = count_reg[i];
        end
        if (in_fire && enq_ok)
        begin
            tail_next[enq_idx]  = (tail_reg[enq_idx] == PTR_W'(DEPTH_PER_LEVEL - 1)) ?
                                  '0 : tail_reg[enq_idx] + 1'b1;
            count_next[enq_idx] = count_reg[enq_idx] + 1'b1;
        end
        if (in_fire && deq_ok)
        begin
            head_next[deq_idx]  = (head_reg[deq_idx] == PTR_W'(DEPTH_PER_LEVEL - 1)) ?
                                  '0 : head_reg[deq_idx] + 1'b1;
            count_next[deq_idx] = count_reg[deq_idx] - 1'b1;
        end
    end

    always_comb
    begin
        any_busy = 1'b0;
        for (int i = 0; i < LEVELS; i++)
        begin
            any_busy = any_busy | (count_next[i] != '0);
        end
    end

    // status of the word entering the memory stage
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        s1_ctl_next   = s1_ctl_reg;
        if (s_axis_tready)
        begin
            s1_valid_next         = s_axis_tvalid;
            s1_ctl_next.deq_ok    = deq_ok;
            s1_ctl_next.lvl       = deq_ok ? mlpf_pkg::LEVEL_W'(deq_idx) : '0;
            s1_ctl_next.all_empty = !any_busy;
            if (in_act == mlpf_pkg::ACT_ENQ)
            begin
                s1_ctl_next.status = enq_ok ? mlpf_pkg::ST_OK : mlpf_pkg::ST_DROP;
            end
            else
            begin
                s1_ctl_next.status = deq_ok ? mlpf_pkg::ST_OK : mlpf_pkg::ST_EMPTY;
            end
        end
    end

    assign res_id = s1_ctl_reg.deq_ok ? mlpf_pkg::TASK_W'(rd_data_reg) : '0;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_user_next  = out_user_reg;
        if (out_free)
        begin
            out_valid_next = s1_valid_reg;
            out_data_next  = mlpf_pkg::M_TDATA_W'({s1_ctl_reg.lvl, res_id});
            out_user_next  = {s1_ctl_reg.all_empty, s1_ctl_reg.status};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LEVELS; i++)
            begin
                head_reg[i]  <= '0;
                tail_reg[i]  <= '0;
                count_reg[i] <= '0;
            end
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_ctl_reg   <= s1_ctl_next;
        out_data_reg <= out_data_next;
        out_user_reg <= out_user_next;
    end

    // a slot written by one word is read no earlier than the next word, so the
    // written data is already in the array and no bypass is needed
    always_ff @(posedge clk)
    begin
        if (in_fire && enq_ok)
        begin
            entry_mem[wr_addr] <= ID_WIDTH'(in_id);
        end
    end

    // read data holds while the memory stage is stalled
    always_ff @(posedge clk)
    begin
        if (in_fire && deq_ok)
        begin
            rd_data_reg <= entry_mem[rd_addr];
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

endmodule

/* src/mlpf_checker.sv */
// ---------------------------------------------------------------------------
// mlpf_checker
// port-level checks on the priority fifo result stream
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "multilevel_priority_fifo_macros.svh"

module mlpf_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic [mlpf_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    input logic [mlpf_pkg::S_TUSER_W-1:0]  s_axis_tuser,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [mlpf_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    input logic [mlpf_pkg::M_TUSER_W-1:0]  m_axis_tuser
);

    logic              res_empty;
    logic              res_drop;
    logic              all_empty;
    logic              in_deq;
    logic              in_fire;

    assign res_empty = m_axis_tuser[mlpf_pkg::STATUS_W-1:0] == mlpf_pkg::ST_EMPTY;
    assign res_drop  = m_axis_tuser[mlpf_pkg::STATUS_W-1:0] == mlpf_pkg::ST_DROP;
    assign all_empty = m_axis_tuser[mlpf_pkg::STATUS_W];
    assign in_deq    = s_axis_tuser[0] == mlpf_pkg::ACT_DEQ;
    assign in_fire   = s_axis_tvalid && s_axis_tready && (s_axis_tdata == s_axis_tdata);

    // a stalled result holds
    `MLPF_ASSERT_NEXT(a_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

    // empty dequeue reports an empty queue and a zero word
    `MLPF_ASSERT_NOW(a_empty, clk, rst_n, m_axis_tvalid && res_empty,
        all_empty && (m_axis_tdata == '0))

    // dropped enqueue carries a zero word
    `MLPF_ASSERT_NOW(a_drop, clk, rst_n, m_axis_tvalid && res_drop,
        m_axis_tdata == '0)

    // no result appears without an accepted word behind it, registered through the memory stage and the output register
    `MLPF_ASSERT_NOW(a_cause, clk, rst_n, $rose(m_axis_tvalid),
        $past(in_fire, 2) && ($past(in_deq, 2) || !res_empty))

endmodule

bind multilevel_priority_fifo mlpf_checker u_mlpf_checker (.*);

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// checks the multilevel priority fifo against its own ready queue predictor;
// directed corner words first, then biased random enqueue and dequeue runs,
// with bursty input, a stalling output and one long output hold-off
// ---------------------------------------------------------------------------

typedef struct packed {
    logic [mlpf_pkg::TASK_W-1:0]  task_id;
    logic [mlpf_pkg::LEVEL_W-1:0] lvl;
    mlpf_pkg::status_t            status;
    logic                         all_empty;
} reply_t;

class ready_queue_board;
    localparam int LEVEL_N = 16;
    localparam int DEPTH_N = 16;

    logic [mlpf_pkg::TASK_W-1:0] level_fifo [LEVEL_N][$];
    reply_t                      expected_replies [$];
    int                          errors;

    function new();
        errors = 0;
    endfunction

    // predicts the reply of one accepted request and queues it
    function void record_request(logic act,
                                 logic [mlpf_pkg::TASK_W-1:0] id,
                                 logic [mlpf_pkg::LEVEL_W-1:0] lvl);
        reply_t r;
        int     i;
        bit     found;
        r     = '0;
        found = 0;
        if (act == mlpf_pkg::ACT_ENQ)
        begin
            if (int'(lvl) >= LEVEL_N || level_fifo[lvl].size() >= DEPTH_N)
                r.status = mlpf_pkg::ST_DROP;
            else
                level_fifo[lvl].push_back(id);
        end
        else
        begin
            r.status = mlpf_pkg::ST_EMPTY;
            for (i = 0; i < LEVEL_N; i++)
            begin
                if (!found && level_fifo[i].size() != 0)
                begin
                    r.task_id = level_fifo[i].pop_front();
                    r.lvl     = mlpf_pkg::LEVEL_W'(i);
                    r.status  = mlpf_pkg::ST_OK;
                    found     = 1;
                end
            end
        end
        r.all_empty = 1'b1;
        for (i = 0; i < LEVEL_N; i++)
            if (level_fifo[i].size() != 0)
                r.all_empty = 1'b0;
        expected_replies.push_back(r);
    endfunction

    function void check_reply(logic [mlpf_pkg::M_TDATA_W-1:0] tdata,
                              logic [mlpf_pkg::M_TUSER_W-1:0] tuser);
        reply_t exp_r;
        if (expected_replies.size() == 0)
        begin
            $error("reply with none expected: tdata %h tuser %h", tdata, tuser);
            errors++;
            return;
        end
        exp_r = expected_replies.pop_front();
        if (tdata[7:0] !== exp_r.task_id)
        begin
            $error("out_task_id: expected %0d, got %0d", exp_r.task_id, tdata[7:0]);
            errors++;
        end
        if (tdata[11:8] !== exp_r.lvl)
        begin
            $error("out_level: expected %0d, got %0d", exp_r.lvl, tdata[11:8]);
            errors++;
        end
        if (tuser[1:0] !== exp_r.status)
        begin
            $error("status: expected %0d, got %0d", exp_r.status, tuser[1:0]);
            errors++;
        end
        if (tuser[2] !== exp_r.all_empty)
        begin
            $error("all_empty: expected %0d, got %0d", exp_r.all_empty, tuser[2]);
            errors++;
        end
    endfunction

    function int pending();
        return expected_replies.size();
    endfunction
endclass

module tb_top;

    localparam int ITEMS    = 1400;
    localparam int HOLD_AT  = 300;
    localparam int HOLD_LEN = 200;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    logic [mlpf_pkg::S_TDATA_W-1:0] s_axis_tdata = '0;
    logic [mlpf_pkg::S_TUSER_W-1:0] s_axis_tuser = '0;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    logic [mlpf_pkg::M_TDATA_W-1:0] m_axis_tdata;
    logic [mlpf_pkg::M_TUSER_W-1:0] m_axis_tuser;

    ready_queue_board board = new();
    int               words_in = 0;
    int               words_sent = 0;
    int               burst_left = 0;

    multilevel_priority_fifo #(
        .LEVELS          (16),
        .DEPTH_PER_LEVEL (16),
        .ID_WIDTH        (8)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // input words are noted before output words are checked
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                board.record_request(s_axis_tuser[0], s_axis_tdata[7:0], s_axis_tdata[11:8]);
                words_in++;
            end
            if (m_axis_tvalid && m_axis_tready)
                board.check_reply(m_axis_tdata, m_axis_tuser);
        end
    end

    // output side: stretches of always ready, light and heavy stalls, one long hold-off
    initial
    begin
        int seg;
        int mode;
        bit held;
        held = 0;
        wait (rst_n);
        forever
        begin
            seg  = $urandom_range(4, 60);
            mode = $urandom_range(0, 2);
            repeat (seg)
            begin
                @(posedge clk);
                if (!held && words_in >= HOLD_AT)
                begin
                    held = 1;
                    m_axis_tready <= 1'b0;
                    repeat (HOLD_LEN) @(posedge clk);
                end
                case (mode)
                    0:       m_axis_tready <= 1'b1;
                    1:       m_axis_tready <= ($urandom_range(0, 1) == 0);
                    default: m_axis_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // offers one word and waits for it to be taken; idles between bursts
    task automatic send_word(logic act, logic [mlpf_pkg::TASK_W-1:0] id,
                             logic [mlpf_pkg::LEVEL_W-1:0] lvl);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= {4'b0, lvl, id};
        do @(posedge clk); while (!s_axis_tready);
        words_sent++;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 48);
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 3);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        else
        begin
            burst_left--;
        end
    endtask

    initial
    begin
        int seg_len;
        int enq_pct;
        int base;
        int drain;
        bit narrow;
        logic act;
        logic [mlpf_pkg::LEVEL_W-1:0] lvl;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty dequeue, id and level extremes, priority order, full level
        send_word(mlpf_pkg::ACT_DEQ, 8'h00, 4'h0);
        send_word(mlpf_pkg::ACT_ENQ, 8'hFF, 4'hF);
        send_word(mlpf_pkg::ACT_ENQ, 8'h00, 4'h0);
        send_word(mlpf_pkg::ACT_ENQ, 8'hAA, 4'h7);
        send_word(mlpf_pkg::ACT_ENQ, 8'h55, 4'h7);
        repeat (4) send_word(mlpf_pkg::ACT_DEQ, 8'hFF, 4'hF);
        for (int i = 0; i < 17; i++)
            send_word(mlpf_pkg::ACT_ENQ, 8'(i * 15), 4'hF);

        // random: segments with their own enqueue bias and level spread
        while (words_sent < ITEMS)
        begin
            seg_len = $urandom_range(20, 80);
            case ($urandom_range(0, 3))
                0:       enq_pct = 20;
                1:       enq_pct = 50;
                2:       enq_pct = 70;
                default: enq_pct = 90;
            endcase
            narrow = $urandom_range(0, 1);
            base   = $urandom_range(0, 14);
            repeat (seg_len)
            begin
                act = ($urandom_range(0, 99) < enq_pct) ? mlpf_pkg::ACT_ENQ : mlpf_pkg::ACT_DEQ;
                lvl = narrow ? mlpf_pkg::LEVEL_W'(base + $urandom_range(0, 1))
                             : mlpf_pkg::LEVEL_W'($urandom_range(0, 15));
                send_word(act, 8'($urandom_range(0, 255)), lvl);
            end
        end
        s_axis_tvalid <= 1'b0;

        drain = 0;
        while (board.pending() != 0 && drain < 20000)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (8) @(posedge clk);
        if (board.pending() != 0)
        begin
            $error("%0d expected replies never arrived", board.pending());
            board.errors++;
        end
        if (board.errors == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

    initial
    begin
        #400000;
        $display("tb_top: FAIL");
        $finish;
    end

endmodule
